// File: hdl/fptdt_pkg.sv
// Package: widths, ASCII codes and shared types of the fixed-point to decimal text block.
package fptdt_pkg;

    localparam int IntBits    = 24;
    localparam int FracBits   = 7;
    localparam int BinBits    = 24;
    localparam int BcdDigits  = 8;
    localparam int BcdBits    = BcdDigits * 4;
    localparam int FracDigits = 7;

    // f/128 == f * 78125 / 10^7
    localparam logic [BinBits-1:0] FRAC_UNIT = 24'd78125;

    localparam logic [6:0] CHAR_MINUS = 7'h2d;
    localparam logic [6:0] CHAR_DOT   = 7'h2e;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;

    typedef logic [BcdBits-1:0] t_bcd;
    typedef logic [BinBits-1:0] t_bin;

    typedef struct packed {
        logic done;
        t_bcd int_bcd;
        t_bcd frac_bcd;
    } t_conv_result;

endpackage

// File: hdl/fptdt_dabble.sv
// Shared conversion step: add 3 to every BCD digit of 5 or more, then shift one binary bit in.
module fptdt_dabble (
    input  fptdt_pkg::t_bcd i_bcd,
    input  fptdt_pkg::t_bin i_bin,
    output fptdt_pkg::t_bcd o_bcd,
    output fptdt_pkg::t_bin o_bin
);

    fptdt_pkg::t_bcd adj;

    always_comb begin
        for (int i = 0; i < fptdt_pkg::BcdDigits; i++) begin
            if (i_bcd[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = i_bcd[i*4 +: 4] + 4'd3;
            end else begin
                adj[i*4 +: 4] = i_bcd[i*4 +: 4];
            end
        end
    end

    assign o_bcd = {adj[fptdt_pkg::BcdBits-2:0], i_bin[fptdt_pkg::BinBits-1]};
    assign o_bin = {i_bin[fptdt_pkg::BinBits-2:0], 1'b0};

endmodule

// File: hdl/fptdt_conv.sv
// Sequencer that runs the integer part, then the scaled fraction, through the shared BCD step.
module fptdt_conv (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [30:0]              i_magnitude,
    output fptdt_pkg::t_conv_result  o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INT  = 2'd1;
    localparam logic [1:0] ST_FRAC = 2'd2;

    localparam logic [4:0] LAST_STEP = 5'(fptdt_pkg::BinBits - 1);

    logic [1:0]                       r_state, n_state;
    logic [4:0]                       r_cnt, n_cnt;
    logic                             r_done, n_done;
    fptdt_pkg::t_bin                  r_bin, n_bin;
    fptdt_pkg::t_bcd                  r_bcd, n_bcd;
    fptdt_pkg::t_bcd                  r_int_bcd, n_int_bcd;
    fptdt_pkg::t_bcd                  r_frac_bcd, n_frac_bcd;
    logic [fptdt_pkg::FracBits-1:0]   r_frac, n_frac;

    fptdt_pkg::t_bcd step_bcd;
    fptdt_pkg::t_bin step_bin;

    fptdt_dabble u_dabble (
        .i_bcd (r_bcd),
        .i_bin (r_bin),
        .o_bcd (step_bcd),
        .o_bin (step_bin)
    );

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_done     = 1'b0;
        n_bin      = r_bin;
        n_bcd      = r_bcd;
        n_int_bcd  = r_int_bcd;
        n_frac_bcd = r_frac_bcd;
        n_frac     = r_frac;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_bin   = i_magnitude[30:7];
                    n_frac  = i_magnitude[6:0];
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = ST_INT;
                end
            end
            ST_INT: begin
                n_bin = step_bin;
                n_bcd = step_bcd;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == LAST_STEP) begin
                    // hold the integer digits, load the fraction scaled to 10^-7 units
                    n_int_bcd = step_bcd;
                    n_bin     = fptdt_pkg::FRAC_UNIT
                                * {{(fptdt_pkg::BinBits - fptdt_pkg::FracBits){1'b0}}, r_frac};
                    n_bcd     = '0;
                    n_cnt     = '0;
                    n_state   = ST_FRAC;
                end
            end
            ST_FRAC: begin
                n_bin = step_bin;
                n_bcd = step_bcd;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == LAST_STEP) begin
                    n_frac_bcd = step_bcd;
                    n_done     = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_int_bcd  <= n_int_bcd;
        r_frac_bcd <= n_frac_bcd;
        r_frac     <= n_frac;
    end

    assign o_res.done     = r_done;
    assign o_res.int_bcd  = r_int_bcd;
    assign o_res.frac_bcd = r_frac_bcd;

endmodule

// File: hdl/fixed_point_to_decimal_text.sv
// Fixed-point word to decimal ASCII text: one word in, one character per output transaction,
// a '-' when bit 31 is set, the integer part, '.', then up to seven fraction digits with trailing
// zeros dropped; o_last_char marks the final character. The converter runs 24 shift-add-3
// steps for the integer part and 24 for the fraction, both on one shared BCD step unit; its
// registered done flag hands the digits to the emitter, which then loads one character per
// cycle (3 to 17 characters) into the output register while the output is not stalled. A new
// word is accepted only after the last one is done: o_stall is high from acceptance until the
// last character is loaded into the output register.
module fixed_point_to_decimal_text (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_character,
    output logic        o_last_char
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [1:0] SEG_SIGN = 2'd0;
    localparam logic [1:0] SEG_INT  = 2'd1;
    localparam logic [1:0] SEG_DOT  = 2'd2;
    localparam logic [1:0] SEG_FRAC = 2'd3;

    localparam logic [2:0] FRAC_TOP = 3'(fptdt_pkg::FracDigits - 1);

    logic [1:0] r_state, n_state;
    logic [1:0] r_seg, n_seg;
    logic [2:0] r_dig, n_dig;
    logic [2:0] r_lead, n_lead;
    logic [2:0] r_fstop, n_fstop;
    logic       r_sign, n_sign;
    logic       r_ovalid, n_ovalid;
    logic [6:0] r_char, n_char;
    logic       r_last, n_last;

    logic                    start;
    logic                    out_free;
    logic [2:0]              lead;
    logic [2:0]              fstop;
    logic [3:0]              int_digit;
    logic [3:0]              frac_digit;
    fptdt_pkg::t_conv_result conv;

    assign start    = (r_state == ST_IDLE) && i_valid;
    assign out_free = !r_ovalid || !i_stall;

    fptdt_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_magnitude (i_word[30:0]),
        .o_res       (conv)
    );

    // highest nonzero integer digit, lowest nonzero fraction digit
    always_comb begin
        lead  = 3'd0;
        fstop = FRAC_TOP;
        for (int i = 0; i < fptdt_pkg::BcdDigits; i++) begin
            if (conv.int_bcd[i*4 +: 4] != 4'd0) begin
                lead = 3'(i);
            end
        end
        for (int i = fptdt_pkg::FracDigits - 1; i >= 0; i--) begin
            if (conv.frac_bcd[i*4 +: 4] != 4'd0) begin
                fstop = 3'(i);
            end
        end
    end

    assign int_digit  = conv.int_bcd[r_dig*4 +: 4];
    assign frac_digit = conv.frac_bcd[r_dig*4 +: 4];

    always_comb begin
        n_state  = r_state;
        n_seg    = r_seg;
        n_dig    = r_dig;
        n_lead   = r_lead;
        n_fstop  = r_fstop;
        n_sign   = r_sign;
        n_ovalid = r_ovalid;
        n_char   = r_char;
        n_last   = r_last;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_sign  = i_word[31];
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv.done) begin
                    n_lead  = lead;
                    n_fstop = fstop;
                    n_dig   = lead;
                    n_seg   = r_sign ? SEG_SIGN : SEG_INT;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_last   = 1'b0;
                    unique case (r_seg)
                        SEG_SIGN: begin
                            n_char = fptdt_pkg::CHAR_MINUS;
                            n_seg  = SEG_INT;
                            n_dig  = r_lead;
                        end
                        SEG_INT: begin
                            n_char = fptdt_pkg::CHAR_ZERO + {3'd0, int_digit};
                            if (r_dig == 3'd0) begin
                                n_seg = SEG_DOT;
                            end else begin
                                n_dig = r_dig - 3'd1;
                            end
                        end
                        SEG_DOT: begin
                            n_char = fptdt_pkg::CHAR_DOT;
                            n_seg  = SEG_FRAC;
                            n_dig  = FRAC_TOP;
                        end
                        SEG_FRAC: begin
                            n_char = fptdt_pkg::CHAR_ZERO + {3'd0, frac_digit};
                            if (r_dig == r_fstop) begin
                                n_last  = 1'b1;
                                n_state = ST_IDLE;
                            end else begin
                                n_dig = r_dig - 3'd1;
                            end
                        end
                        default: begin
                            n_seg = SEG_INT;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_seg    <= SEG_SIGN;
            r_dig    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seg    <= n_seg;
            r_dig    <= n_dig;
            r_ovalid <= n_ovalid;
        end
        r_lead  <= n_lead;
        r_fstop <= n_fstop;
        r_sign  <= n_sign;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last_char = r_last;

endmodule

// File: tb/tb_fixed_point_to_decimal_text.sv
// Testbench for fixed_point_to_decimal_text: directed and random words checked against a text predictor.
module tb_fixed_point_to_decimal_text;

    localparam int ClkPeriod   = 12;
    localparam int ResetCycles = 8;
    localparam int DrainCycles = 80;
    localparam int RandomWords = 350;
    localparam int CycleLimit  = 400000;

    typedef struct packed {
        logic [6:0] character;
        logic       last_char;
    } t_text_char;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [31:0] i_word      = '0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [6:0]  o_character;
    logic        o_last_char;

    t_text_char expected_text[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int words_sent    = 0;
    int negative_sent = 0;
    int chars_checked = 0;
    int cycle_count   = 0;

    fixed_point_to_decimal_text dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_word      (i_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

    initial begin
        forever #(ClkPeriod / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("%0t: timeout after %0d cycles, %0d characters still expected",
                     $time, cycle_count, expected_text.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [31:0] make_word(input logic sign, input int unsigned int_part,
                                              input int unsigned frac_part);
        return {sign, int_part[fptdt_pkg::IntBits-1:0], frac_part[fptdt_pkg::FracBits-1:0]};
    endfunction

    // Queue the characters the block must emit for one word.
    task automatic predict_text(input logic [31:0] word);
        int unsigned int_part;
        int unsigned frac_scaled;
        int unsigned int_digits[10];
        int unsigned frac_digits[fptdt_pkg::FracDigits];
        int          n_int;
        int          keep;
        t_text_char  item;
        int_part    = word[fptdt_pkg::FracBits +: fptdt_pkg::IntBits];
        frac_scaled = word[fptdt_pkg::FracBits-1:0] * fptdt_pkg::FRAC_UNIT;
        n_int       = 0;
        keep        = 0;
        item.last_char = 1'b0;
        if (word[31]) begin
            item.character = fptdt_pkg::CHAR_MINUS;
            expected_text.push_back(item);
        end
        do begin
            int_digits[n_int] = int_part % 10;
            int_part          = int_part / 10;
            n_int++;
        end while (int_part != 0);
        for (int i = n_int - 1; i >= 0; i--) begin
            item.character = fptdt_pkg::CHAR_ZERO + 7'(int_digits[i]);
            expected_text.push_back(item);
        end
        item.character = fptdt_pkg::CHAR_DOT;
        expected_text.push_back(item);
        for (int i = fptdt_pkg::FracDigits - 1; i >= 0; i--) begin
            frac_digits[i] = frac_scaled % 10;
            frac_scaled    = frac_scaled / 10;
        end
        // drop trailing zeros, keep leading ones
        for (int i = 0; i < fptdt_pkg::FracDigits; i++) begin
            if (frac_digits[i] != 0) keep = i + 1;
        end
        if (keep == 0) keep = 1;
        for (int i = 0; i < keep; i++) begin
            item.character = fptdt_pkg::CHAR_ZERO + 7'(frac_digits[i]);
            item.last_char = (i == keep - 1);
            expected_text.push_back(item);
        end
    endtask

    // Offer one word, hold it until accepted, then idle at random.
    task automatic send_word(input logic [31:0] word);
        i_valid <= 1'b1;
        i_word  <= word;
        do @(posedge i_clk); while (o_stall);
        predict_text(word);
        words_sent++;
        if (word[31]) negative_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // Output side: random stall and per-field compare against the oldest expectation.
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_text.size() == 0) begin
                $display("%0t: unexpected character, expected none, actual %h last %b",
                         $time, o_character, o_last_char);
                error_count++;
            end else begin
                want = expected_text.pop_front();
                chars_checked++;
                if (o_character !== want.character) begin
                    $display("%0t: character mismatch, expected %h, actual %h",
                             $time, want.character, o_character);
                    error_count++;
                end
                if (o_last_char !== want.last_char) begin
                    $display("%0t: last_char mismatch, expected %b, actual %b",
                             $time, want.last_char, o_last_char);
                    error_count++;
                end
            end
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic test_signs_and_zero();
        send_word(make_word(1'b0, 0, 0));
        send_word(make_word(1'b1, 0, 0));
        send_word(make_word(1'b1, 0, 32));
        send_word(make_word(1'b1, 7, 0));
    endtask

    task automatic test_integer_extremes();
        send_word(make_word(1'b0, 1, 0));
        send_word(make_word(1'b0, 10, 0));
        send_word(make_word(1'b0, 100, 0));
        send_word(make_word(1'b0, 1000000, 0));
        send_word(make_word(1'b0, 9999999, 0));
        send_word(make_word(1'b0, 10000000, 0));
        send_word(make_word(1'b0, 24'hff_ffff, 0));
        send_word(32'hffff_ffff);
        send_word(make_word(1'b1, 123, 100));
    endtask

    task automatic test_fraction_digits();
        send_word(make_word(1'b0, 0, 1));
        send_word(make_word(1'b0, 0, 2));
        send_word(make_word(1'b0, 0, 8));
        send_word(make_word(1'b0, 0, 16));
        send_word(make_word(1'b0, 0, 64));
        send_word(make_word(1'b0, 0, 127));
        send_word(make_word(1'b0, 5, 3));
        send_word(make_word(1'b1, 42, 96));
    endtask

    task automatic test_pause_until_drained();
        send_word(make_word(1'b0, 31, 1));
        send_word(make_word(1'b1, 99, 127));
        wait_drained();
    endtask

    task automatic test_random_words(input int count);
        int unsigned pick;
        logic [31:0] word;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            word = $urandom();
            if (pick < 25) begin
                word = make_word(word[31], $urandom_range(999), word[6:0]);
            end else if (pick < 35) begin
                word[6:0] = '0;
            end else if (pick < 45) begin
                word[30:7] = '0;
            end else if (pick < 52) begin
                word[30:7] = '1;
            end
            send_word(word);
        end
    endtask

    initial begin
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_signs_and_zero();
        test_integer_extremes();
        test_fraction_digits();
        test_pause_until_drained();

        send_idle_pct = 36;
        recv_idle_pct = 51;
        test_random_words(RandomWords / 3);
        send_idle_pct = 51;
        recv_idle_pct = 36;
        test_random_words(RandomWords / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_words(RandomWords - 2 * (RandomWords / 3));

        wait_drained();

        $display("Converted %0d words (%0d negative) into %0d checked characters,",
                 words_sent, negative_sent, chars_checked);
        $display("covering sign, zero, integer and fraction extremes under three stall mixes.");
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", error_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/fptdt_pkg.sv
hdl/fptdt_dabble.sv
hdl/fptdt_conv.sv
hdl/fixed_point_to_decimal_text.sv
tb/tb_fixed_point_to_decimal_text.sv
